@@ src/fbmgn_pkg.sv @@
// Shared constants, types and the normalisation table for the fBm height pipeline.
// No dependencies; every other file of the block imports this package.
package fbmgn_pkg;

	// Block dimensions.
	localparam int MAX_OCTAVES = 10;
	localparam int GRID_W      = 12;
	localparam int FRAC_W      = 16;
	localparam int STEP_W      = 32;
	localparam int POS_W       = GRID_W + STEP_W;
	localparam int LAT_W       = POS_W + MAX_OCTAVES - 1;
	localparam int OCT_W       = 4;

	// Number of register stages in one octave lane.
	localparam int OCT_STAGES  = 11;

	// Hash multipliers and the per-octave seed offset.
	localparam logic [31:0] HASH_MUL_X = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
	localparam logic [31:0] HASH_MUL_S = 32'd2246822519;
	localparam logic [31:0] HASH_MUL_M = 32'd1274126177;
	localparam logic [31:0] SEED_STEP  = 32'd1013;

	// Fixed-point one in the lattice fraction format.
	localparam int ONE_Q = 1 << FRAC_W;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_COORD_STEP   = 2'd0,
		REG_NOISE_SEED   = 2'd1,
		REG_OCTAVE_COUNT = 2'd2,
		REG_RIDGE_MIX    = 2'd3
	} cfg_reg_t;

	// Mixed noise of one octave, signed Q2.16.
	typedef logic signed [18:0] mix_t;

	// Reciprocal of the summed octave weights, with the 0.95 stretch folded in.
	function automatic logic [16:0] norm_recip(input logic [OCT_W-1:0] k);
		logic [16:0] r;
		begin
			case (k)
				4'd1:    r = 17'd124518;
				4'd2:    r = 17'd83012;
				4'd3:    r = 17'd71153;
				4'd4:    r = 17'd66410;
				4'd5:    r = 17'd64268;
				4'd6:    r = 17'd63247;
				4'd7:    r = 17'd62749;
				4'd8:    r = 17'd62503;
				4'd9:    r = 17'd62381;
				default: r = 17'd62320;
			endcase
			return r;
		end
	endfunction

endpackage

@@ src/fbmgn_octave.sv @@
// One octave lane: lattice hash, quintic fade, bilinear blend and ridge mix.
// Depends on fbmgn_pkg; instantiated once per octave by the top level.
module fbmgn_octave import fbmgn_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [OCT_W-1:0]    oct_idx,
	input  logic [POS_W-1:0]    pos_x,
	input  logic [POS_W-1:0]    pos_z,
	input  logic [31:0]         seed_base,
	input  logic [16:0]         ridge_w,
	output mix_t                mix
);

	// Stage 1 signals.
	logic [LAT_W-1:0] lat_x, lat_z;
	logic [31:0]      xi, zi, seed;
	logic [15:0]      xf, zf;
	logic [31:0]      xa_s1, za_s1, sa_s1, ttx_s1, ttz_s1;
	logic [15:0]      xf_s1, zf_s1;

	// Stage 2 signals.
	logic [31:0] hsum [4];
	logic [31:0] h_s2 [4];
	logic [31:0] t3x_s2, t3z_s2;
	logic [20:0] inx_s2, inz_s2;
	logic [15:0] xf_s2, zf_s2;

	// Stage 3 signals.
	logic [31:0] hm_s3 [4];
	logic [36:0] ux_s3, uz_s3;
	logic [15:0] xf_s3, zf_s3;

	// Stage 4 signals.
	logic [31:0]        hf [4];
	logic signed [17:0] dx0, dx1, dz0, dz1;
	logic signed [18:0] n00_s4, n10_s4, n01_s4, n11_s4;
	logic [16:0]        u_s4, v_s4;

	// Stages 5 to 11.
	logic signed [19:0] d0, d1, dl, dm;
	logic signed [37:0] p0_s5, p1_s5, pv_s7, ff_s9;
	logic signed [18:0] n00_s5, n01_s5, l0_s6, l1_s6, l0_s7, n_s8, fd_s8, n_s9, n_s10;
	logic [16:0]        v_s5, v_s6;
	logic signed [18:0] nn, absn;
	logic signed [19:0] folded;
	logic signed [38:0] pr_s10;
	logic signed [19:0] msum;
	mix_t               mix_s11;

	function automatic logic signed [18:0] grad(input logic [2:0] sel,
			input logic signed [17:0] gx, input logic signed [17:0] gz);
		logic signed [18:0] ex, ez, g;
		begin
			ex = {gx[17], gx};
			ez = {gz[17], gz};
			case (sel)
				3'd0:    g = ex + ez;
				3'd1:    g = ex - ez;
				3'd2:    g = ez - ex;
				3'd3:    g = -ex - ez;
				3'd4:    g = ex;
				3'd5:    g = -ex;
				3'd6:    g = ez;
				default: g = -ez;
			endcase
			return g;
		end
	endfunction

	// Scale into this octave's lattice and split integer from fraction.
	always_comb begin
		lat_x = {{(MAX_OCTAVES-1){1'b0}}, pos_x} << oct_idx;
		lat_z = {{(MAX_OCTAVES-1){1'b0}}, pos_z} << oct_idx;
		xi    = lat_x[FRAC_W +: 32];
		zi    = lat_z[FRAC_W +: 32];
		xf    = lat_x[FRAC_W-1:0];
		zf    = lat_z[FRAC_W-1:0];
		seed  = seed_base + 32'(oct_idx) * SEED_STEP;
	end

	// Stage 1: hash products and fraction squares.
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s1  <= xi * HASH_MUL_X;
			za_s1  <= zi * HASH_MUL_Z;
			sa_s1  <= seed * HASH_MUL_S;
			ttx_s1 <= 32'(xf) * 32'(xf);
			ttz_s1 <= 32'(zf) * 32'(zf);
			xf_s1  <= xf;
			zf_s1  <= zf;
		end
	end

	// Corner hash seeds; the +1 corners add the multiplier itself.
	always_comb begin
		hsum[0] = xa_s1 + za_s1 + sa_s1;
		hsum[1] = xa_s1 + HASH_MUL_X + za_s1 + sa_s1;
		hsum[2] = xa_s1 + za_s1 + HASH_MUL_Z + sa_s1;
		hsum[3] = xa_s1 + HASH_MUL_X + za_s1 + HASH_MUL_Z + sa_s1;
	end

	// Stage 2: cube of the fraction and the inner fade polynomial.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) h_s2[c] <= hsum[c];
			t3x_s2 <= 32'(ttx_s1[31:16]) * 32'(xf_s1);
			t3z_s2 <= 32'(ttz_s1[31:16]) * 32'(zf_s1);
			inx_s2 <= 21'd655360 + 21'(ttx_s1[31:16]) * 21'd6 - 21'(xf_s1) * 21'd15;
			inz_s2 <= 21'd655360 + 21'(ttz_s1[31:16]) * 21'd6 - 21'(zf_s1) * 21'd15;
			xf_s2  <= xf_s1;
			zf_s2  <= zf_s1;
		end
	end

	// Stage 3: hash scramble multiply and fade product.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) hm_s3[c] <= (h_s2[c] ^ (h_s2[c] >> 13)) * HASH_MUL_M;
			ux_s3 <= 37'(t3x_s2[31:16]) * 37'(inx_s2);
			uz_s3 <= 37'(t3z_s2[31:16]) * 37'(inz_s2);
			xf_s3 <= xf_s2;
			zf_s3 <= zf_s2;
		end
	end

	// Final hash fold and corner gradients; the far corner offsets are fraction minus one.
	always_comb begin
		for (int c = 0; c < 4; c++) hf[c] = hm_s3[c] ^ (hm_s3[c] >> 16);
		dx0 = {2'b00, xf_s3};
		dx1 = {2'b11, xf_s3};
		dz0 = {2'b00, zf_s3};
		dz1 = {2'b11, zf_s3};
	end

	// Stage 4: corner values and fade weights.
	always_ff @(posedge clk) begin
		if (en) begin
			n00_s4 <= grad(hf[0][2:0], dx0, dz0);
			n10_s4 <= grad(hf[1][2:0], dx1, dz0);
			n01_s4 <= grad(hf[2][2:0], dx0, dz1);
			n11_s4 <= grad(hf[3][2:0], dx1, dz1);
			u_s4   <= ux_s3[32:16];
			v_s4   <= uz_s3[32:16];
		end
	end

	assign d0 = 20'(n10_s4) - 20'(n00_s4);
	assign d1 = 20'(n11_s4) - 20'(n01_s4);

	// Stage 5: blend products along x.
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s5  <= $signed({1'b0, u_s4}) * d0;
			p1_s5  <= $signed({1'b0, u_s4}) * d1;
			n00_s5 <= n00_s4;
			n01_s5 <= n01_s4;
			v_s5   <= v_s4;
		end
	end

	// Stage 6: finish the x blends.
	always_ff @(posedge clk) begin
		if (en) begin
			l0_s6 <= n00_s5 + $signed(p0_s5[34:16]);
			l1_s6 <= n01_s5 + $signed(p1_s5[34:16]);
			v_s6  <= v_s5;
		end
	end

	assign dl = 20'(l1_s6) - 20'(l0_s6);

	// Stage 7: blend product along z.
	always_ff @(posedge clk) begin
		if (en) begin
			pv_s7 <= $signed({1'b0, v_s6}) * dl;
			l0_s7 <= l0_s6;
		end
	end

	// Noise value and its distance from the ridge.
	always_comb begin
		nn   = l0_s7 + $signed(pv_s7[34:16]);
		absn = nn[18] ? -nn : nn;
	end

	// Stage 8: noise and fold distance.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s8  <= nn;
			fd_s8 <= 19'sd65536 - absn;
		end
	end

	// Stage 9: square of the fold distance.
	always_ff @(posedge clk) begin
		if (en) begin
			ff_s9 <= fd_s8 * fd_s8;
			n_s9  <= n_s8;
		end
	end

	always_comb begin
		folded = $signed({2'b00, ff_s9[32:16], 1'b0}) - 20'sd65536;
		dm     = folded - 20'(n_s9);
	end

	// Stage 10: ridge weighting product.
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s10 <= dm * $signed({1'b0, ridge_w});
			n_s10  <= n_s9;
		end
	end

	assign msum = 20'(n_s10) + $signed(pr_s10[35:16]);

	// Stage 11: mixed octave value.
	always_ff @(posedge clk) begin
		if (en) begin
			mix_s11 <= msum[18:0];
		end
	end

	assign mix = mix_s11;

endmodule

@@ src/fbm_gradient_noise_height_top.sv @@
// Top level of the fBm terrain height pipeline: configuration, octave lanes, normalisation.
// Depends on fbmgn_pkg and fbmgn_octave.

// One grid point (grid_x, grid_z) enters per cycle and one height leaves per cycle unless
// out_ready stalls; all octave lanes run side by side, so the depth is one lane's eleven
// stages plus the scaling, summing tree, normalisation, clamp, square and output stages.
// The whole pipeline stalls only while a finished height waits at the output and
// out_ready is low. Configuration writes are always taken (cfg_ready is high) and must
// only be issued while no transfer is in flight.
module fbm_gradient_noise_height_top import fbmgn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [GRID_W-1:0] grid_x,
	input  logic [GRID_W-1:0] grid_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       height,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int NUM_STAGES = OCT_STAGES + 8;

	logic [31:0]          coord_step_q, noise_seed_q;
	logic [OCT_W-1:0]     octave_count_q, k_eff;
	logic [16:0]          ridge_mix_q, ridge_w;
	logic [NUM_STAGES-1:0] vld_q;
	logic                 en;
	logic [POS_W-1:0]     px_s1, pz_s1;
	mix_t                 mix [MAX_OCTAVES];
	logic signed [29:0]   term [MAX_OCTAVES];
	logic signed [29:0]   p_s13 [5];
	logic signed [29:0]   q0_s14, q1_s14, sum_s15;
	logic signed [47:0]   prod_s16;
	logic signed [22:0]   vv;
	logic [16:0]          v_s17;
	logic [33:0]          sq_s18;
	logic [15:0]          height_s19;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_step_q   <= 32'd65536;
			noise_seed_q   <= '0;
			octave_count_q <= 4'd1;
			ridge_mix_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COORD_STEP:   coord_step_q   <= cfg_data;
				REG_NOISE_SEED:   noise_seed_q   <= cfg_data;
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[OCT_W-1:0];
				REG_RIDGE_MIX:    ridge_mix_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Limited octave count and ridge weight.
	always_comb begin
		if (octave_count_q == '0) begin
			k_eff = 4'd1;
		end else if (octave_count_q > OCT_W'(MAX_OCTAVES)) begin
			k_eff = OCT_W'(MAX_OCTAVES);
		end else begin
			k_eff = octave_count_q;
		end
		ridge_w = ridge_mix_q[16] ? 17'd65536 : ridge_mix_q;
	end

	// The pipeline advances unless a finished height is held at the output.
	assign en        = !vld_q[NUM_STAGES-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NUM_STAGES-1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_STAGES-2:0], in_valid};
		end
	end

	// Stage 1: grid position scaled to lattice units.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= POS_W'(grid_x) * POS_W'(coord_step_q);
			pz_s1 <= POS_W'(grid_z) * POS_W'(coord_step_q);
		end
	end

	// Octave lanes, stages 2 to 12.
	for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
		fbmgn_octave u_oct (
			.clk       (clk),
			.en        (en),
			.oct_idx   (OCT_W'(g)),
			.pos_x     (px_s1),
			.pos_z     (pz_s1),
			.seed_base (noise_seed_q),
			.ridge_w   (ridge_w),
			.mix       (mix[g])
		);
	end

	// Octave weights; lanes beyond the octave count contribute nothing.
	always_comb begin
		for (int o = 0; o < MAX_OCTAVES; o++) begin
			if (OCT_W'(o) < k_eff) begin
				term[o] = 30'(mix[o]) <<< (MAX_OCTAVES - 1 - o);
			end else begin
				term[o] = '0;
			end
		end
	end

	// Stages 13 to 15: summing tree.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 5; j++) p_s13[j] <= term[2*j] + term[2*j+1];
			q0_s14  <= p_s13[0] + p_s13[1] + p_s13[2];
			q1_s14  <= p_s13[3] + p_s13[4];
			sum_s15 <= q0_s14 + q1_s14;
		end
	end

	// Stage 16: normalisation product.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s16 <= sum_s15 * $signed({1'b0, norm_recip(k_eff)});
		end
	end

	// Recentre about one half; stage 17 clamps to the unit range.
	assign vv = 23'sd32768 + 23'($signed(prod_s16[47:26]));

	// Stage 17: clamped height before squaring.
	always_ff @(posedge clk) begin
		if (en) begin
			if (vv < 0) begin
				v_s17 <= '0;
			end else if (vv > 23'sd65536) begin
				v_s17 <= 17'd65536;
			end else begin
				v_s17 <= vv[16:0];
			end
		end
	end

	// Stage 18: square.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s18 <= 34'(v_s17) * 34'(v_s17);
		end
	end

	// Stage 19: output register with saturation at full height.
	always_ff @(posedge clk) begin
		if (en) begin
			height_s19 <= sq_s18[32] ? 16'hFFFF : sq_s18[31:16];
		end
	end

	assign height = height_s19;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the fBm gradient-noise terrain height pipeline.
// Depends on fbmgn_pkg and fbm_gradient_noise_height_top; predicts each height in place.
`timescale 1ns / 1ps

module tb_top;
	import fbmgn_pkg::*;

	// Gradient directions picked by the low three hash bits.
	typedef enum logic [2:0] {
		GRAD_XPZP, GRAD_XPZM, GRAD_XMZP, GRAD_XMZM,
		GRAD_XP, GRAD_XM, GRAD_ZP, GRAD_ZM
	} grad_dir_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 25;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [GRID_W-1:0] grid_x;
	logic [GRID_W-1:0] grid_z;
	logic              out_valid;
	logic              out_ready;
	logic [15:0]       height;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [31:0]       cfg_data;

	// Shadow copy of the configuration registers.
	logic [31:0] step_reg;
	logic [31:0] seed_reg;
	logic [3:0]  octaves_reg;
	logic [16:0] ridge_reg;

	logic [15:0] heights_pending[$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	bit          quiet;

	fbm_gradient_noise_height_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .grid_x(grid_x), .grid_z(grid_z),
		.out_valid(out_valid), .out_ready(out_ready), .height(height),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Lattice corner hash.
	function automatic logic [31:0] corner_hash(logic [31:0] xi, logic [31:0] zi,
			logic [31:0] seed);
		logic [31:0] h;
		h = xi * HASH_MUL_X + zi * HASH_MUL_Z + seed * HASH_MUL_S;
		h = (h ^ (h >> 13)) * HASH_MUL_M;
		return h ^ (h >> 16);
	endfunction

	function automatic longint grad_dot(grad_dir_t dir, longint dx, longint dz);
		case (dir)
			GRAD_XPZP: return dx + dz;
			GRAD_XPZM: return dx - dz;
			GRAD_XMZP: return -dx + dz;
			GRAD_XMZM: return -dx - dz;
			GRAD_XP:   return dx;
			GRAD_XM:   return -dx;
			GRAD_ZP:   return dz;
			default:   return -dz;
		endcase
	endfunction

	// Quintic fade curve in Q.16.
	function automatic longint fade_curve(longint t);
		longint t2;
		longint t3;
		t2 = (t * t) >>> FRAC_W;
		t3 = (t2 * t) >>> FRAC_W;
		return (t3 * (6 * t2 - 15 * t + 10 * ONE_Q)) >>> FRAC_W;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + ((w * (b - a)) >>> FRAC_W);
	endfunction

	function automatic longint octave_noise(logic [31:0] xi, longint xf, logic [31:0] zi,
			longint zf, logic [31:0] seed);
		longint u;
		longint v;
		longint n00;
		longint n10;
		longint n01;
		longint n11;
		u = fade_curve(xf);
		v = fade_curve(zf);
		n00 = grad_dot(grad_dir_t'(corner_hash(xi, zi, seed) & 7), xf, zf);
		n10 = grad_dot(grad_dir_t'(corner_hash(xi + 1, zi, seed) & 7), xf - ONE_Q, zf);
		n01 = grad_dot(grad_dir_t'(corner_hash(xi, zi + 1, seed) & 7), xf, zf - ONE_Q);
		n11 = grad_dot(grad_dir_t'(corner_hash(xi + 1, zi + 1, seed) & 7),
			xf - ONE_Q, zf - ONE_Q);
		return blend(blend(n00, n10, u), blend(n01, n11, u), v);
	endfunction

	// Height of one grid point under the current shadow configuration.
	function automatic logic [15:0] terrain_height(logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gz);
		logic [63:0] px;
		logic [63:0] pz;
		logic [63:0] lx;
		logic [63:0] lz;
		longint k;
		longint r;
		longint n;
		longint fd;
		longint folded;
		longint mix;
		longint sum;
		longint weights;
		longint recip;
		longint v;
		longint sq;
		px = 64'(gx) * 64'(step_reg);
		pz = 64'(gz) * 64'(step_reg);
		k = longint'(octaves_reg);
		if (k < 1) k = 1;
		if (k > MAX_OCTAVES) k = MAX_OCTAVES;
		r = (ridge_reg > 17'd65536) ? 65536 : longint'(ridge_reg);
		sum = 0;
		for (int o = 0; o < k; o++) begin
			lx = px << o;
			lz = pz << o;
			n = octave_noise(lx[47:16], longint'(lx[15:0]), lz[47:16], longint'(lz[15:0]),
				seed_reg + 32'(o) * SEED_STEP);
			fd = ONE_Q - ((n < 0) ? -n : n);
			folded = 2 * ((fd * fd) >>> FRAC_W) - ONE_Q;
			mix = n + (((folded - n) * r) >>> 16);
			sum += mix * (longint'(1) << (MAX_OCTAVES - 1 - o));
		end
		weights = (longint'(1) << MAX_OCTAVES) - (longint'(1) << (MAX_OCTAVES - k));
		recip = (19 * (longint'(1) << (MAX_OCTAVES + 16)) + 10 * weights) / (20 * weights);
		v = ONE_Q / 2 + ((sum * recip) >>> (MAX_OCTAVES + 16));
		if (v < 0) v = 0;
		if (v > ONE_Q) v = ONE_Q;
		sq = (v * v) >>> FRAC_W;
		if (sq > 65535) sq = 65535;
		return sq[15:0];
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Result side: random back-pressure and comparison against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
			if (out_valid && out_ready) begin
				if (heights_pending.size() == 0) begin
					report_mismatch($sformatf("unexpected height %0d", height));
				end else if (height !== heights_pending[0]) begin
					report_mismatch($sformatf("height %0d, predicted %0d",
						height, heights_pending[0]));
					void'(heights_pending.pop_front());
				end else begin
					void'(heights_pending.pop_front());
				end
			end
		end
	end

	// Watchdog on cycles in which no transfer happens on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Waits until every predicted height has arrived, then lets the pipeline settle.
	task automatic drain_results();
		while (heights_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write, issued only with the pipeline empty.
	task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COORD_STEP:   step_reg = data;
			REG_NOISE_SEED:   seed_reg = data;
			REG_OCTAVE_COUNT: octaves_reg = data[3:0];
			default:          ridge_reg = data[16:0];
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [31:0] stp, logic [31:0] sd, logic [31:0] oct,
			logic [31:0] rdg);
		write_reg(REG_COORD_STEP, stp);
		write_reg(REG_NOISE_SEED, sd);
		write_reg(REG_OCTAVE_COUNT, oct);
		write_reg(REG_RIDGE_MIX, rdg);
	endtask

	// Sends one grid point, with random idle cycles ahead of it unless quiet is set.
	task automatic send_point(logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gz);
		while (!quiet && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		grid_x   <= gx;
		grid_z   <= gz;
		do @(posedge clk); while (!in_ready);
		heights_pending.push_back(terrain_height(gx, gz));
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Points at reset configuration.
	task automatic test_reset_defaults();
		send_point(12'd0, 12'd0);
		send_point(12'd4095, 12'd4095);
		send_point(12'd1, 12'd2048);
		stop_sending();
	endtask

	// Field extremes, octave and ridge saturation, lattice wrap.
	task automatic test_extremes();
		configure(32'h0000_8000, 32'h8000_0000, 0, 0);
		send_point(12'd4095, 12'd0);
		send_point(12'd0, 12'd4095);
		stop_sending();
		configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 10, 65536);
		send_point(12'd4095, 12'd4095);
		send_point(12'd1, 12'd4094);
		send_point(12'd2730, 12'd1365);
		stop_sending();
		configure(32'h0001_2345, 32'hFFFF_FFFF, 15, 17'h1FFFF);
		send_point(12'd4095, 12'd7);
		send_point(12'd100, 12'd3000);
		stop_sending();
		configure(0, 0, 11, 32768);
		send_point(12'd4095, 12'd4095);
		stop_sending();
		configure(32'h8000_0000, 32'd12345, 1, 65535);
		send_point(12'd4095, 12'd4095);
		send_point(12'd3, 12'd5);
		stop_sending();
		configure(32'd700, 32'd99, 5, 65537);
		for (int i = 0; i < 6; i++) send_point(12'($urandom), 12'($urandom));
		stop_sending();
	endtask

	// Random configurations, each followed by a burst of random points.
	task automatic test_random_terrain();
		logic [31:0] stp;
		for (int phase = 0; phase < 11; phase++) begin
			case ($urandom_range(3))
				0:       stp = $urandom;
				1:       stp = $urandom_range(1 << 18);
				2:       stp = $urandom_range(1 << 14);
				default: stp = 32'h0001_0000;
			endcase
			configure(stp, $urandom,
				(phase % 3 == 0) ? $urandom : $urandom_range(MAX_OCTAVES, 1),
				(phase % 4 == 0) ? $urandom : $urandom_range(65536));
			quiet = (phase == 4);
			for (int i = 0; i < 150; i++) begin
				send_point(12'($urandom), 12'($urandom));
				// Let the pipeline empty completely once mid-phase.
				if (phase == 2 && i == 75) begin
					stop_sending();
					while (heights_pending.size() != 0) @(posedge clk);
				end
			end
			quiet = 1'b0;
			stop_sending();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		grid_x = '0;
		grid_z = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_COORD_STEP;
		cfg_data = '0;
		quiet = 1'b0;
		step_reg = 32'd65536;
		seed_reg = '0;
		octaves_reg = 4'd1;
		ridge_reg = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_extremes();
		test_random_terrain();
		drain_results();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
src/fbmgn_pkg.sv
src/fbmgn_octave.sv
src/fbm_gradient_noise_height_top.sv
sim/tb_top.sv
